// ----- src/assert_macros.svh -----
// assertion macros shared by the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is asserted
`define DEQI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// same-cycle implication
`define DEQI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DEQI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/deqi_pkg.sv -----
// shared types and constants of the indexed double-ended queue
`default_nettype none

package deqi_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_READ_INDEX = 3'd2,
    FUNC_READ_FRONT = 3'd3,
    FUNC_READ_BACK  = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/deqi_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none

module deqi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/deqi_ctrl.sv -----
// controller state machine of the indexed double-ended queue
`default_nettype none

module deqi_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output deqi_pkg::cmd_t     cmd_o
);

  deqi_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deqi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      deqi_pkg::S_IDLE: begin
        if (start_i) state_d = deqi_pkg::S_EXEC;
      end
      deqi_pkg::S_EXEC: begin
        state_d = deqi_pkg::S_RESP;
      end
      deqi_pkg::S_RESP: begin
        state_d = deqi_pkg::S_IDLE;
      end
      default: begin
        state_d = deqi_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o     = 1'b1;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    cmd_o.resp = 1'b0;
    case (state_q)
      deqi_pkg::S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      deqi_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      deqi_pkg::S_RESP: begin
        cmd_o.resp = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/deqi_dpath.sv -----
// datapath: head pointer, fill count, ring store and result registers
`default_nettype none
`include "assert_macros.svh"

module deqi_dpath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire deqi_pkg::cmd_t                   cmd_i,
  input  wire logic [deqi_pkg::FUNC_W-1:0]      func_i,
  input  wire logic [deqi_pkg::VALUE_W-1:0]     value_i,
  input  wire logic [deqi_pkg::INDEX_W-1:0]     index_i,
  output logic      [deqi_pkg::VALUE_W-1:0]     data_o,
  output logic      [deqi_pkg::COUNT_W-1:0]     count_o,
  output logic                                  is_empty_o,
  output logic      [deqi_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = deqi_pkg::INDEX_W;
  localparam int unsigned PW   = (CW > IW) ? CW : IW;
  localparam int unsigned VW   = deqi_pkg::VALUE_W;
  localparam int unsigned OCW  = deqi_pkg::COUNT_W;
  localparam logic [CW-1:0]  CNT_FULL = CW'(DEPTH);
  localparam logic [AW:0]    SUM_LIM  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0]  PTR_LAST = AW'(DEPTH - 1);

  deqi_pkg::func_e   func_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [IW-1:0]     index_q;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  deqi_pkg::status_e status_q, status_d;
  logic              rd_ok_q, rd_ok_d;

  logic              full;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              re;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     tail_pos;
  logic [PW-1:0]     idx_ext;
  logic [PW-1:0]     cnt_ext;
  logic [CW-1:0]     cnt_dec;
  logic [DATA_WIDTH-1:0] rd_data;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SUM_LIM) begin
      sum = sum - SUM_LIM;
    end
    return sum[AW-1:0];
  endfunction

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= deqi_pkg::func_e'(func_i);
      value_q <= DATA_WIDTH'(value_i);
      index_q <= index_i;
    end
  end

  assign full     = (count_q == CNT_FULL);
  assign head_dec = (head_q == '0) ? PTR_LAST : head_q - AW'(1);
  assign tail_pos = wrap_add(head_q, count_q[AW-1:0]);
  assign idx_ext  = PW'(index_q);
  assign cnt_ext  = PW'(count_q);
  assign cnt_dec  = count_q - CW'(1);
  assign raddr    = wrap_add(head_q, pos);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = deqi_pkg::STATUS_OK;
    rd_ok_d  = 1'b0;
    we       = 1'b0;
    waddr    = tail_pos;
    re       = 1'b0;
    pos      = '0;
    case (func_q)
      deqi_pkg::FUNC_PUSH_FRONT: begin
        if (full) begin
          status_d = deqi_pkg::STATUS_FULL;
        end else begin
          we      = 1'b1;
          waddr   = head_dec;
          head_d  = head_dec;
          count_d = count_q + CW'(1);
        end
      end
      deqi_pkg::FUNC_PUSH_BACK: begin
        if (full) begin
          status_d = deqi_pkg::STATUS_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      deqi_pkg::FUNC_READ_INDEX: begin
        pos = idx_ext[AW-1:0];
        if (idx_ext < cnt_ext) begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
        end else begin
          status_d = deqi_pkg::STATUS_RANGE;
        end
      end
      deqi_pkg::FUNC_READ_FRONT: begin
        if (count_q != '0) begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
        end else begin
          status_d = deqi_pkg::STATUS_RANGE;
        end
      end
      deqi_pkg::FUNC_READ_BACK: begin
        pos = cnt_dec[AW-1:0];
        if (count_q != '0) begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
        end else begin
          status_d = deqi_pkg::STATUS_RANGE;
        end
      end
      default: begin
        status_d = deqi_pkg::STATUS_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  deqi_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec & we),
    .waddr_i (waddr),
    .wdata_i (value_q),
    .re_i    (cmd_i.exec & re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign data_o     = rd_ok_q ? VW'(rd_data) : '0;
  assign count_o    = OCW'(count_q);
  assign is_empty_o = (count_q == '0);
  assign status_o   = status_q;

  `DEQI_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_FULL, "fill count above depth")
  `DEQI_ASSERT_IMP(a_full_refusal, clk_i, rst_ni,
                   cmd_i.resp && (status_q == deqi_pkg::STATUS_FULL), full,
                   "push refused while queue not full")
  `DEQI_ASSERT_NXT(a_read_keeps_state, clk_i, rst_ni,
                   cmd_i.exec && !we, (count_q == $past(count_q)) && (head_q == $past(head_q)),
                   "queue state changed without a write")

endmodule

`default_nettype wire

// ----- src/double_ended_queue_indexed_top.sv -----
// top level of the indexed double-ended queue
//
// Each operation runs through the controller states: the request is latched at
// the start transfer, the EXEC state updates the pointers and writes or reads
// the ring ram, and in the RESP state the result sits on the result ports.
// busy_o stays high in the EXEC and RESP states after a start transfer, and a
// new start is taken in the cycle after done_o. The result is shown on the
// result ports for exactly one cycle with done_o high; the receiver cannot
// stall it and must take it then. count_o reports the fill count after the
// operation (low five bits) and status_o flags range errors and refused
// pushes.
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue_indexed_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [deqi_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [deqi_pkg::VALUE_W-1:0]  value_i,
  input  wire logic [deqi_pkg::INDEX_W-1:0]  index_i,
  output logic                               done_o,
  output logic      [deqi_pkg::VALUE_W-1:0]  data_o,
  output logic      [deqi_pkg::COUNT_W-1:0]  count_o,
  output logic                               is_empty_o,
  output logic      [deqi_pkg::STATUS_W-1:0] status_o
);

  deqi_pkg::cmd_t cmd;

  deqi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  deqi_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .func_i     (func_i),
    .value_i    (value_i),
    .index_i    (index_i),
    .data_o     (data_o),
    .count_o    (count_o),
    .is_empty_o (is_empty_o),
    .status_o   (status_o)
  );

  assign done_o = cmd.resp;

  `DEQI_ASSERT_IMP(a_done_after_start, clk_i, rst_ni,
                   $past(start_i && !busy_o, 2) && $past(rst_ni, 2), done_o,
                   "result not given two cycles after start transfer")
  `DEQI_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o && !busy_o,
                   "result strobe longer than one cycle")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// testbench for the indexed double-ended queue: directed and random operations checked
module tb;

  localparam int unsigned FUNC_W         = deqi_pkg::FUNC_W;
  localparam int unsigned VALUE_W        = deqi_pkg::VALUE_W;
  localparam int unsigned INDEX_W        = deqi_pkg::INDEX_W;
  localparam int unsigned COUNT_W        = deqi_pkg::COUNT_W;
  localparam int unsigned STATUS_W       = deqi_pkg::STATUS_W;
  localparam int unsigned DEPTH          = 16;
  localparam int unsigned DATA_WIDTH     = 32;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned RANDOM_OPS     = 1950;
  localparam int unsigned DRAIN_EVERY    = 400;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned FUNC_CODES     = 1 << FUNC_W;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    bit                 drain_first;
  } deque_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } deque_result_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start_i = 1'b0;
  logic [FUNC_W-1:0]   func_i  = '0;
  logic [VALUE_W-1:0]  value_i = '0;
  logic [INDEX_W-1:0]  index_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [VALUE_W-1:0]  data_o;
  logic [COUNT_W-1:0]  count_o;
  logic                is_empty_o;
  logic [STATUS_W-1:0] status_o;

  deque_op_t     pending_ops[$];
  deque_result_t expected_results[int unsigned];
  int unsigned   issued_cnt   = 0;
  int unsigned   answered_cnt = 0;
  int unsigned   mismatch_cnt = 0;
  int unsigned   gap_left     = 0;
  int unsigned   burst_left   = 0;
  int unsigned   idle_cycles  = 0;

  // predictor state
  logic [VALUE_W-1:0] ring_mem[DEPTH];
  int unsigned        ring_head = 0;
  int unsigned        ring_fill = 0;

  double_ended_queue_indexed_top #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .func_i    (func_i),
    .value_i   (value_i),
    .index_i   (index_i),
    .done_o    (done_o),
    .data_o    (data_o),
    .count_o   (count_o),
    .is_empty_o(is_empty_o),
    .status_o  (status_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic deque_result_t deque_apply(input logic [FUNC_W-1:0] op,
                                                input logic [VALUE_W-1:0] val,
                                                input logic [INDEX_W-1:0] idx);
    deque_result_t r;
    int unsigned   pos;
    r = '0;
    r.status = deqi_pkg::STATUS_OK;
    case (op)
      deqi_pkg::FUNC_PUSH_FRONT, deqi_pkg::FUNC_PUSH_BACK: begin
        if (ring_fill >= DEPTH) begin
          r.status = deqi_pkg::STATUS_FULL;
        end else begin
          if (op == deqi_pkg::FUNC_PUSH_FRONT) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_mem[ring_head] = val;
          end else begin
            ring_mem[(ring_head + ring_fill) % DEPTH] = val;
          end
          ring_fill++;
        end
      end
      deqi_pkg::FUNC_READ_INDEX, deqi_pkg::FUNC_READ_FRONT, deqi_pkg::FUNC_READ_BACK: begin
        if (op == deqi_pkg::FUNC_READ_INDEX) pos = 32'(idx);
        else if (op == deqi_pkg::FUNC_READ_FRONT) pos = 0;
        else pos = ring_fill - 1;
        if (ring_fill != 0 && pos < ring_fill) r.data = ring_mem[(ring_head + pos) % DEPTH];
        else r.status = deqi_pkg::STATUS_RANGE;
      end
      default: begin
        r.status = deqi_pkg::STATUS_RANGE;
      end
    endcase
    r.count    = ring_fill[COUNT_W-1:0];
    r.is_empty = (ring_fill == 0);
    return r;
  endfunction

  task automatic add_op(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                        input logic [INDEX_W-1:0] idx, input bit drain);
    deque_op_t op;
    op.func        = f;
    op.value       = v;
    op.index       = idx;
    op.drain_first = drain;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    logic      take;
    deque_op_t nxt;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      take = start_i && !busy_o;
      if (take) begin
        expected_results[issued_cnt] = deque_apply(func_i, value_i, index_i);
        issued_cnt <= issued_cnt + 1;
      end
      if (start_i && !take) begin
        // hold the request until it is taken
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (pending_ops.size() != 0 && pending_ops[0].drain_first &&
                   answered_cnt != issued_cnt + take) begin
        start_i <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        nxt = pending_ops.pop_front();
        func_i  <= nxt.func;
        value_i <= nxt.value;
        index_i <= nxt.index;
        start_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(24, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // receiver: every result is checked against the oldest prediction
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && done_o) begin
      if (answered_cnt == issued_cnt) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: data %h count %0d empty %0d status %0d",
                   data_o, count_o, is_empty_o, status_o);
      end else begin
        want = expected_results[answered_cnt];
        expected_results.delete(answered_cnt);
        answered_cnt <= answered_cnt + 1;
        if (data_o !== want.data || count_o !== want.count ||
            is_empty_o !== want.is_empty || status_o !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("transfer %0d: expected data %h count %0d empty %0d status %0d",
                     answered_cnt, want.data, want.count, want.is_empty, want.status);
            $display("transfer %0d: got data %h count %0d empty %0d status %0d",
                     answered_cnt, data_o, count_o, is_empty_o, status_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned pick;
    bit          drain;

    // empty queue, unknown code, wrap of the head below zero
    add_op(deqi_pkg::FUNC_READ_FRONT, '0, '0, 1'b0);
    add_op(deqi_pkg::FUNC_READ_BACK, '0, '0, 1'b0);
    add_op(deqi_pkg::FUNC_READ_INDEX, '0, '0, 1'b0);
    add_op(FUNC_W'(FUNC_CODES - 1), '1, '1, 1'b0);
    add_op(deqi_pkg::FUNC_PUSH_BACK, '1, '0, 1'b0);
    add_op(deqi_pkg::FUNC_PUSH_FRONT, '0, '1, 1'b0);
    add_op(deqi_pkg::FUNC_READ_INDEX, '0, 4'd1, 1'b0);
    add_op(deqi_pkg::FUNC_READ_INDEX, '1, 4'd2, 1'b0);
    add_op(deqi_pkg::FUNC_READ_FRONT, '0, '0, 1'b0);
    add_op(deqi_pkg::FUNC_READ_BACK, '0, '0, 1'b0);
    // fill to the top, then refused pushes
    for (k = 0; k < DEPTH - 2; k++)
      add_op(k[0] ? deqi_pkg::FUNC_PUSH_BACK : deqi_pkg::FUNC_PUSH_FRONT, $urandom(), '0,
             1'b0);
    add_op(deqi_pkg::FUNC_PUSH_FRONT, $urandom(), '0, 1'b0);
    add_op(deqi_pkg::FUNC_PUSH_BACK, $urandom(), '0, 1'b1);
    add_op(deqi_pkg::FUNC_READ_INDEX, '0, '1, 1'b0);

    for (k = 0; k < RANDOM_OPS; k++) begin
      pick  = $urandom_range(99, 0);
      drain = (k % DRAIN_EVERY == DRAIN_EVERY - 1);
      if (pick < 30)
        add_op(deqi_pkg::FUNC_READ_INDEX, $urandom(),
               INDEX_W'($urandom_range(DEPTH - 1, 0)), drain);
      else if (pick < 45)
        add_op(deqi_pkg::FUNC_READ_FRONT, $urandom(), INDEX_W'($urandom()), drain);
      else if (pick < 60)
        add_op(deqi_pkg::FUNC_READ_BACK, $urandom(), INDEX_W'($urandom()), drain);
      else if (pick < 75)
        add_op(deqi_pkg::FUNC_PUSH_FRONT, $urandom(), INDEX_W'($urandom()), drain);
      else if (pick < 90)
        add_op(deqi_pkg::FUNC_PUSH_BACK, $urandom(), INDEX_W'($urandom()), drain);
      else
        add_op(FUNC_W'($urandom_range(FUNC_CODES - 1, int'(deqi_pkg::FUNC_READ_BACK) + 1)),
               $urandom(), INDEX_W'($urandom()), drain);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_ops.size() != 0 || start_i || answered_cnt != issued_cnt);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (answered_cnt != issued_cnt)
      $display("%0d results never arrived", issued_cnt - answered_cnt);
    if (mismatch_cnt == 0 && answered_cnt == issued_cnt) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
